### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the mouse packet framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MPF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define MPF_ASSERT_NEVER(lbl, expr) \
	`MPF_ASSERT(lbl, !(expr))
`else
`define MPF_ASSERT(lbl, prop)
`define MPF_ASSERT_NEVER(lbl, expr)
`endif
`endif

### hw/rtl/mpf_pkg.sv
// Widths and codes shared by the mouse packet framer files.
package mpf_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 6;
	localparam int SYNC_BIT = 3;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

endpackage

### hw/rtl/mpf_req_if.sv
// Request channel of the mouse packet framer: mouse bytes and read requests.
interface mpf_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [mpf_pkg::BYTE_W-1:0]    mouse_byte;
	logic [mpf_pkg::COUNT_W-1:0]   read_count;

	modport source (output valid, output req_type, output mouse_byte, output read_count,
		input ready);
	modport sink (input valid, input req_type, input mouse_byte, input read_count,
		output ready);
endinterface

### hw/rtl/mpf_rsp_if.sv
// Result channel of the mouse packet framer: bytes drained from the queue.
interface mpf_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mpf_pkg::BYTE_W-1:0]    out_byte;
	logic                          status;
	logic                          last;

	modport source (output valid, output out_byte, output status, output last,
		input ready);
	modport sink (input valid, input out_byte, input status, input last,
		output ready);
endinterface

### hw/rtl/mpf_ring.sv
// Byte queue storage: one write port and one registered read port.
module mpf_ring #(
	parameter int DEPTH  = 49,
	parameter int ADDR_W = 6
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [mpf_pkg::BYTE_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [mpf_pkg::BYTE_W-1:0]  rd_data
);

	logic [mpf_pkg::BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/mouse_packet_framer_fifo_unit.sv
// Mouse packet framer with an overwriting byte queue of 3*PACKETS_HELD+1 slots.
// A mouse byte is accepted while idle; the third byte of a packet then starts a push,
// since the single ring write port stores the three packet bytes one per cycle.
// A read of up to n bytes issues one ring read per cycle unless the output stalls;
// results pass the ring and output registers; new requests wait for its last read.
// Reset clears the packet position, both queue pointers and all valid flags.
`include "assert_macros.svh"

module mouse_packet_framer_fifo_unit #(
	parameter int PACKETS_HELD = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	mpf_req_if.sink    req,
	mpf_rsp_if.source  rsp
);

	localparam int RING_SLOTS = 3 * PACKETS_HELD + 1;
	localparam int ADDR_W = $clog2(RING_SLOTS);
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(RING_SLOTS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PUSH = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	localparam int BW = mpf_pkg::BYTE_W;
	localparam int CW = mpf_pkg::COUNT_W;

	function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + ADDR_W'(1);
	endfunction

	logic [1:0]        state_q;
	logic [1:0]        pos_q;
	logic [1:0]        push_cnt_q;
	logic [ADDR_W-1:0] wp_q;
	logic [ADDR_W-1:0] rp_q;
	logic [CW-1:0]     rem_q;
	logic              empty_q;
	logic [BW-1:0]     held0_q;
	logic [BW-1:0]     held1_q;
	logic [BW-1:0]     tail_q;

	logic              inflight_s1;
	logic              status_s1;
	logic              last_s1;
	logic [BW-1:0]     ring_byte_s1;

	logic              out_v_q;
	logic [BW-1:0]     out_byte_q;
	logic              out_status_q;
	logic              out_last_q;
	logic              skid_v_q;
	logic [BW-1:0]     skid_byte_q;
	logic              skid_status_q;
	logic              skid_last_q;

	logic              req_fire;
	logic              out_free;
	logic              issue;
	logic              issue_last;
	logic [ADDR_W-1:0] rp_next;
	logic [ADDR_W-1:0] wp_next;
	logic [BW-1:0]     push_data;
	logic [BW-1:0]     land_byte;
	logic              wr_en;
	logic              rd_en;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_v_q || rsp.ready;
	assign issue     = (state_q == ST_READ) && !skid_v_q &&
		!(inflight_s1 && out_v_q && !rsp.ready);
	assign rp_next    = next_slot(rp_q);
	assign wp_next    = next_slot(wp_q);
	assign issue_last = empty_q || (rem_q == CW'(1)) || (rp_next == wp_q);
	assign land_byte  = (status_s1 == mpf_pkg::STATUS_EMPTY) ? '0 : ring_byte_s1;
	assign wr_en      = (state_q == ST_PUSH);
	assign rd_en      = issue && !empty_q;

	always_comb begin
		case (push_cnt_q)
			2'd0:    push_data = held0_q;
			2'd1:    push_data = held1_q;
			default: push_data = tail_q;
		endcase
	end

	mpf_ring #(
		.DEPTH  (RING_SLOTS),
		.ADDR_W (ADDR_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (push_data),
		.rd_en   (rd_en),
		.rd_addr (rp_q),
		.rd_data (ring_byte_s1)
	);

	// Pushes and reads never overlap: the sequencer runs one of them at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= 2'd0;
			push_cnt_q  <= 2'd0;
			wp_q        <= '0;
			rp_q        <= '0;
			rem_q       <= '0;
			empty_q     <= 1'b0;
			inflight_s1 <= 1'b0;
		end else begin
			inflight_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.req_type == mpf_pkg::REQ_READ) begin
							state_q <= ST_READ;
							rem_q   <= (req.read_count == '0) ? CW'(1) : req.read_count;
							empty_q <= (rp_q == wp_q);
						end else begin
							case (pos_q)
								2'd1: pos_q <= 2'd2;
								2'd2: begin
									pos_q      <= 2'd0;
									push_cnt_q <= 2'd0;
									state_q    <= ST_PUSH;
								end
								default: pos_q <= req.mouse_byte[mpf_pkg::SYNC_BIT] ? 2'd1 : 2'd0;
							endcase
						end
					end
				end
				ST_PUSH: begin
					wp_q <= wp_next;
					if (wp_next == rp_q) begin
						rp_q <= rp_next;
					end
					push_cnt_q <= push_cnt_q + 2'd1;
					if (push_cnt_q == 2'd2) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (issue) begin
						if (!empty_q) begin
							rp_q <= rp_next;
						end
						rem_q <= rem_q - CW'(1);
						if (issue_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && req.req_type == mpf_pkg::REQ_BYTE) begin
			if (pos_q == 2'd1) begin
				held1_q <= req.mouse_byte;
			end else if (pos_q == 2'd2) begin
				tail_q <= req.mouse_byte;
			end else begin
				held0_q <= req.mouse_byte;
			end
		end
		if (issue) begin
			status_s1 <= empty_q ? mpf_pkg::STATUS_EMPTY : mpf_pkg::STATUS_OK;
			last_s1   <= issue_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= inflight_s1;
				end
			end else if (inflight_s1) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_byte_q   <= skid_byte_q;
				out_status_q <= skid_status_q;
				out_last_q   <= skid_last_q;
			end else begin
				out_byte_q   <= land_byte;
				out_status_q <= status_s1;
				out_last_q   <= last_s1;
			end
		end else if (inflight_s1) begin
			skid_byte_q   <= land_byte;
			skid_status_q <= status_s1;
			skid_last_q   <= last_s1;
		end
	end

	assign rsp.valid    = out_v_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.status   = out_status_q;
	assign rsp.last     = out_last_q;

	`MPF_ASSERT(skid_needs_out, skid_v_q |-> out_v_q)
	`MPF_ASSERT(landing_skid_free, inflight_s1 |-> !skid_v_q)
	`MPF_ASSERT_NEVER(empty_not_final, rsp.valid && rsp.status && (!rsp.last || rsp.out_byte != '0))
	`MPF_ASSERT_NEVER(read_during_push, rd_en && wr_en)

endmodule
